[hdl/hci_uart_packet_deframer_defines.svh]
// Assertion macros shared by the deframer RTL.
`ifndef HCI_UART_PACKET_DEFRAMER_DEFINES_SVH
`define HCI_UART_PACKET_DEFRAMER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define HUD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define HUD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/hud_pkg.sv]
`timescale 1ns / 1ps

package hud_pkg;

  // Parser phase codes
  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_EVENT  = 2'd1;
  localparam logic [1:0] PHASE_ACL    = 2'd2;
  localparam logic [1:0] PHASE_VENDOR = 2'd3;

  // Packet type bytes
  localparam logic [7:0] TYPE_EVENT  = 8'h04;
  localparam logic [7:0] TYPE_ACL    = 8'h02;
  localparam logic [7:0] TYPE_VENDOR = 8'h05;

  // Packet kind codes on the result channel
  localparam logic [1:0] KIND_EVENT  = 2'd0;
  localparam logic [1:0] KIND_ACL    = 2'd1;
  localparam logic [1:0] KIND_VENDOR = 2'd2;

  localparam int unsigned IDX_W = 17;

  localparam logic [IDX_W-1:0] EVENT_HDR_BYTES = 17'd3;
  localparam logic [IDX_W-1:0] ACL_HDR_BYTES   = 17'd5;
  localparam logic [IDX_W-1:0] ACL_LEN_LO_POS  = 17'd4;
  localparam logic [7:0]       VENDOR_LEN_RST  = 8'd10;
  localparam logic [7:0]       VENDOR_LEN_MIN  = 8'd2;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [1:0]       kind;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] index;
  } hud_result_t;

endpackage

[hdl/hci_uart_packet_deframer.sv]
// H4-style HCI UART deframer.
// Input channel: one received UART byte per transfer (in_valid / in_stall,
// payload in_rx_byte). Output channel: one result per byte that belongs to a
// packet (out_valid / out_stall): the byte, its packet kind, its index in the
// packet and first / last marks. Bytes seen while idle that are not a packet
// type (0x04 event, 0x02 ACL, 0x05 vendor) are dropped without a result.
// A result is registered in the output register (in the skid register while
// the receiver stalls). Throughput: one byte per cycle while in_stall is low,
// set by the single parse step between the state registers and output register.
// A two-entry output buffer (output register plus skid register) lets the
// block take a byte while a result is waiting; in_stall rises only once the
// skid register holds a result, and drops the cycle after the receiver
// takes one. Results are never lost or reordered while out_stall is high.
// cfg_wr_en / cfg_wr_data write the vendor packet length (total bytes,
// header included; values below 2 act as 2). Write only while idle.
// Reset (rst_n low, synchronous) returns the parser to idle, empties the
// output buffer and sets the vendor packet length to 10.
`timescale 1ns / 1ps
`include "hci_uart_packet_deframer_defines.svh"

module hci_uart_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic [1:0]  out_packet_kind,
  output logic        out_first_of_packet,
  output logic        out_last_of_packet,
  output logic [16:0] out_byte_index,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import hud_pkg::*;

  logic [1:0]       phase_r, phase_nxt;
  logic [IDX_W-1:0] count_r, count_nxt;
  logic [15:0]      pay_len_r, pay_len_nxt;
  logic             len_known_r, len_known_nxt;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic [7:0]       vendor_len_r;

  hud_result_t      res;
  logic             res_valid;
  logic [IDX_W-1:0] count_inc;
  logic [IDX_W-1:0] end_count;
  logic [7:0]       vendor_lim;
  logic             in_xfer;
  logic             push;
  logic             take;

  hud_result_t      out_r, skid_r;
  logic             out_valid_r, skid_valid_r;

  assign in_xfer = in_valid && !in_stall;
  assign take    = out_valid_r && !out_stall;
  assign push    = in_xfer && res_valid;

  // Parse one byte against the current phase
  always_comb begin
    phase_nxt      = phase_r;
    count_nxt      = count_r;
    pay_len_nxt    = pay_len_r;
    len_known_nxt  = len_known_r;
    len_lo_nxt     = len_lo_r;
    res_valid      = 1'b0;
    res.data_byte  = in_rx_byte;
    res.kind       = KIND_EVENT;
    res.first      = 1'b0;
    res.last       = 1'b0;
    res.index      = count_r;
    count_inc      = count_r + 17'd1;
    end_count      = '0;
    vendor_lim     = (vendor_len_r < VENDOR_LEN_MIN) ? VENDOR_LEN_MIN : vendor_len_r;
    unique case (phase_r)
      PHASE_IDLE: begin
        res.first   = 1'b1;
        res.index   = '0;
        res_valid   = 1'b1;
        case (in_rx_byte)
          TYPE_EVENT: begin
            phase_nxt = PHASE_EVENT;
            res.kind  = KIND_EVENT;
          end
          TYPE_ACL: begin
            phase_nxt = PHASE_ACL;
            res.kind  = KIND_ACL;
          end
          TYPE_VENDOR: begin
            phase_nxt = PHASE_VENDOR;
            res.kind  = KIND_VENDOR;
          end
          default: res_valid = 1'b0;
        endcase
        if (res_valid) begin
          count_nxt     = 17'd1;
          pay_len_nxt   = '0;
          len_known_nxt = 1'b0;
          len_lo_nxt    = '0;
        end
      end
      PHASE_EVENT: begin
        res_valid = 1'b1;
        res.kind  = KIND_EVENT;
        count_nxt = count_inc;
        if (count_inc == EVENT_HDR_BYTES) begin
          pay_len_nxt   = {8'd0, in_rx_byte};
          len_known_nxt = 1'b1;
        end
        end_count = {1'b0, pay_len_nxt} + EVENT_HDR_BYTES;
        res.last  = len_known_nxt && (count_inc == end_count);
      end
      PHASE_ACL: begin
        res_valid = 1'b1;
        res.kind  = KIND_ACL;
        count_nxt = count_inc;
        if (count_inc == ACL_LEN_LO_POS) begin
          len_lo_nxt = in_rx_byte;
        end
        if (count_inc == ACL_HDR_BYTES) begin
          pay_len_nxt   = {in_rx_byte, len_lo_r};
          len_known_nxt = 1'b1;
        end
        end_count = {1'b0, pay_len_nxt} + ACL_HDR_BYTES;
        res.last  = len_known_nxt && (count_inc == end_count);
      end
      PHASE_VENDOR: begin
        res_valid = 1'b1;
        res.kind  = KIND_VENDOR;
        count_nxt = count_inc;
        res.last  = count_inc >= {9'd0, vendor_lim};
      end
      default: res_valid = 1'b0;
    endcase
    if (res.last) begin
      phase_nxt = PHASE_IDLE;
    end
  end

  // Advance parser state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PHASE_IDLE;
      count_r     <= '0;
      pay_len_r   <= '0;
      len_known_r <= 1'b0;
      len_lo_r    <= '0;
    end else if (in_xfer) begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      pay_len_r   <= pay_len_nxt;
      len_known_r <= len_known_nxt;
      len_lo_r    <= len_lo_nxt;
    end
  end

  // Hold the vendor packet length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vendor_len_r <= VENDOR_LEN_RST;
    end else if (cfg_wr_en) begin
      vendor_len_r <= cfg_wr_data;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_stall            = skid_valid_r;
  assign out_valid           = out_valid_r;
  assign out_data_byte       = out_r.data_byte;
  assign out_packet_kind     = out_r.kind;
  assign out_first_of_packet = out_r.first;
  assign out_last_of_packet  = out_r.last;
  assign out_byte_index      = out_r.index;

  `HUD_ASSERT_NOW(a_skid_needs_out, skid_valid_r, out_valid_r, "skid full with output empty")
  `HUD_ASSERT_NEXT(a_push_stalled_to_skid, push && out_valid_r && out_stall,
                   skid_valid_r, "stalled result not parked in skid")
  `HUD_ASSERT_NOW(a_first_index_zero, out_valid_r && out_r.first,
                  out_r.index == '0, "header byte with nonzero index")
  `HUD_ASSERT_NEXT(a_last_returns_idle, push && res.last,
                   phase_r == PHASE_IDLE, "parser not idle after last byte")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import hud_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam hud_result_t NO_RESULT = '0;

  // One row of the directed table: the byte to send, an optional vendor length
  // to write first, and an expected result typed in by hand where it is obvious.
  typedef struct {
    logic [7:0]  rx;
    bit          set_len;
    logic [7:0]  len_val;
    bit          typed;
    bit          gives;
    hud_result_t res;
  } frame_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_data_byte;
  logic [1:0]  out_packet_kind;
  logic        out_first_of_packet;
  logic        out_last_of_packet;
  logic [16:0] out_byte_index;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;

  // Deframer tracking state
  logic [1:0]  trk_phase;
  logic [16:0] trk_count;
  logic [15:0] trk_len;
  bit          trk_len_known;
  logic [7:0]  trk_len_lo;
  logic [7:0]  vendor_len_seen;

  hud_result_t framed_q[$];
  frame_row_t  typed_rows_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          packet_bytes_sent = 0;
  int          cur_vendor_len = 10;
  bit          no_gaps = 1'b0;
  int          stall_hold = 0;

  frame_row_t framing_rows [24] = '{
    '{8'h00, 1'b0, 8'h00, 1'b1, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 8'h00, 1'b1, 1'b0, NO_RESULT},
    '{8'h04, 1'b0, 8'h00, 1'b1, 1'b1, '{8'h04, KIND_EVENT, 1'b1, 1'b0, 17'd0}},
    '{8'hFF, 1'b0, 8'h00, 1'b1, 1'b1, '{8'hFF, KIND_EVENT, 1'b0, 1'b0, 17'd1}},
    '{8'h00, 1'b0, 8'h00, 1'b1, 1'b1, '{8'h00, KIND_EVENT, 1'b0, 1'b1, 17'd2}},
    '{8'h02, 1'b0, 8'h00, 1'b1, 1'b1, '{8'h02, KIND_ACL, 1'b1, 1'b0, 17'd0}},
    '{8'h80, 1'b0, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h7F, 1'b0, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 8'h00, 1'b1, 1'b1, '{8'h00, KIND_ACL, 1'b0, 1'b1, 17'd4}},
    '{8'h05, 1'b1, 8'h00, 1'b1, 1'b1, '{8'h05, KIND_VENDOR, 1'b1, 1'b0, 17'd0}},
    '{8'h5A, 1'b0, 8'h00, 1'b1, 1'b1, '{8'h5A, KIND_VENDOR, 1'b0, 1'b1, 17'd1}},
    '{8'h05, 1'b1, 8'h01, 1'b0, 1'b0, NO_RESULT},
    '{8'hA5, 1'b0, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h05, 1'b1, 8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'h11, 1'b0, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h22, 1'b0, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h33, 1'b0, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h44, 1'b1, 8'h03, 1'b0, 1'b0, NO_RESULT},
    '{8'h04, 1'b1, 8'h0A, 1'b0, 1'b0, NO_RESULT},
    '{8'hC3, 1'b0, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h3C, 1'b0, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h06, 1'b0, 8'h00, 1'b0, 1'b0, NO_RESULT}
  };

  hci_uart_packet_deframer uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_data_byte       (out_data_byte),
    .out_packet_kind     (out_packet_kind),
    .out_first_of_packet (out_first_of_packet),
    .out_last_of_packet  (out_last_of_packet),
    .out_byte_index      (out_byte_index),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the tracker by one accepted byte; return 1 when the byte gives a result.
  function automatic bit deframe_byte(input logic [7:0] b, output hud_result_t r);
    logic [16:0] lim;
    bit          done;
    r = '0;
    done = 1'b0;
    if (trk_phase == PHASE_IDLE) begin
      case (b)
        TYPE_EVENT: begin
          trk_phase = PHASE_EVENT;
          r.kind = KIND_EVENT;
        end
        TYPE_ACL: begin
          trk_phase = PHASE_ACL;
          r.kind = KIND_ACL;
        end
        TYPE_VENDOR: begin
          trk_phase = PHASE_VENDOR;
          r.kind = KIND_VENDOR;
        end
        default: return 1'b0;
      endcase
      trk_count = 17'd1;
      trk_len = 16'd0;
      trk_len_known = 1'b0;
      trk_len_lo = 8'd0;
      r.data_byte = b;
      r.first = 1'b1;
      return 1'b1;
    end
    r.index = trk_count;
    trk_count = trk_count + 17'd1;
    case (trk_phase)
      PHASE_EVENT: begin
        r.kind = KIND_EVENT;
        if (trk_count == EVENT_HDR_BYTES) begin
          trk_len = {8'd0, b};
          trk_len_known = 1'b1;
        end
        done = trk_len_known && (trk_count == {1'b0, trk_len} + EVENT_HDR_BYTES);
      end
      PHASE_ACL: begin
        r.kind = KIND_ACL;
        if (trk_count == ACL_LEN_LO_POS) trk_len_lo = b;
        if (trk_count == ACL_HDR_BYTES) begin
          trk_len = {b, trk_len_lo};
          trk_len_known = 1'b1;
        end
        done = trk_len_known && (trk_count == {1'b0, trk_len} + ACL_HDR_BYTES);
      end
      default: begin
        r.kind = KIND_VENDOR;
        lim = {9'd0, vendor_len_seen};
        if (lim < {9'd0, VENDOR_LEN_MIN}) lim = {9'd0, VENDOR_LEN_MIN};
        done = (trk_count >= lim);
      end
    endcase
    if (done) trk_phase = PHASE_IDLE;
    r.data_byte = b;
    r.last = done;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [16:0] want,
                             input logic [16:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // Check results against the oldest expectation, then predict accepted bytes
  always @(posedge clk) begin : track
    hud_result_t want;
    hud_result_t pred;
    frame_row_t  row;
    bit          gives;
    if (!rst_n) begin
      trk_phase = PHASE_IDLE;
      trk_count = '0;
      trk_len = '0;
      trk_len_known = 1'b0;
      trk_len_lo = '0;
      vendor_len_seen = VENDOR_LEN_RST;
      idle_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (framed_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none got byte %h kind %0d index %0d",
                   $time, out_data_byte, out_packet_kind, out_byte_index);
        end else begin
          want = framed_q.pop_front();
          check_field("data_byte", {9'd0, want.data_byte}, {9'd0, out_data_byte});
          check_field("packet_kind", {15'd0, want.kind}, {15'd0, out_packet_kind});
          check_field("first_of_packet", {16'd0, want.first}, {16'd0, out_first_of_packet});
          check_field("last_of_packet", {16'd0, want.last}, {16'd0, out_last_of_packet});
          check_field("byte_index", want.index, out_byte_index);
        end
      end
      if (in_valid && !in_stall) begin
        gives = deframe_byte(in_rx_byte, pred);
        if (typed_rows_q.size() != 0) begin
          row = typed_rows_q.pop_front();
          if (row.typed) begin
            gives = row.gives;
            pred = row.res;
          end
        end
        if (gives) framed_q.push_back(pred);
      end
      if (cfg_wr_en) vendor_len_seen = cfg_wr_data;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Receiver stalls: mostly short runs, some long stalls and long free stretches
  always @(posedge clk) begin : stall_gen
    int pick;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        out_stall <= 1'b0;
        stall_hold <= $urandom_range(0, 4);
      end else if (pick < 85) begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(0, 2);
      end else if (pick < 95) begin
        out_stall <= 1'b0;
        stall_hold <= $urandom_range(20, 80);
      end else begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(8, 40);
      end
    end
  end

  // Drive one byte, after a random gap, and hold it until the transfer
  task automatic send_byte(input logic [7:0] b);
    int gap;
    int pick;
    gap = 0;
    if (!no_gaps) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) gap = $urandom_range(1, 3);
      else if (pick < 36) gap = $urandom_range(8, 40);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_payload(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Hold off the sender until every expected result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    // let the tracker record the last transfer before looking at the queue
    @(posedge clk);
    while (framed_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_vendor_len(input logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_vendor_len = int'((v < VENDOR_LEN_MIN) ? VENDOR_LEN_MIN : v);
  endtask

  task automatic send_event(input int len);
    send_byte(TYPE_EVENT);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(len[7:0]);
    send_payload(len);
    packet_bytes_sent += len + 3;
  endtask

  task automatic send_acl(input int len);
    send_byte(TYPE_ACL);
    send_payload(2);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    send_payload(len);
    packet_bytes_sent += len + 5;
  endtask

  task automatic send_vendor();
    send_byte(TYPE_VENDOR);
    send_payload(cur_vendor_len - 1);
    packet_bytes_sent += cur_vendor_len;
  endtask

  task automatic send_random_packet();
    int pick;
    int sel;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    no_gaps = ($urandom_range(0, 3) == 0);
    if (pick < 8) begin
      // noise bytes, mostly dropped by an idle parser
      send_payload($urandom_range(1, 3));
    end else if (pick < 45) begin
      if (sel < 75) send_event($urandom_range(0, 6));
      else if (sel < 97) send_event($urandom_range(7, 40));
      else send_event($urandom_range(200, 255));
    end else if (pick < 80) begin
      if (sel < 70) send_acl($urandom_range(0, 8));
      else send_acl($urandom_range(9, 300));
    end else begin
      send_vendor();
    end
  endtask

  // Watchdog: end the run when nothing transfers for too long
  initial begin
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int sec;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (framing_rows[i]) begin
      if (framing_rows[i].set_len) begin
        drain_results();
        write_vendor_len(framing_rows[i].len_val);
      end
      typed_rows_q.push_back(framing_rows[i]);
      send_byte(framing_rows[i].rx);
    end

    // Random packets, one vendor length per section
    packet_bytes_sent = 0;
    for (sec = 0; sec < 6; sec++) begin
      if (sec != 0) begin
        drain_results();
        case (sec)
          1: write_vendor_len(8'd2);
          2: write_vendor_len(8'd255);
          3: write_vendor_len(8'($urandom_range(2, 24)));
          4: write_vendor_len(8'($urandom_range(0, 255)));
          default: write_vendor_len(8'd1);
        endcase
      end
      while (packet_bytes_sent < (sec + 1) * 190) send_random_packet();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && framed_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/hud_pkg.sv
hdl/hci_uart_packet_deframer.sv
tb/sv/testbench.sv
